### sv/pbba_pkg.sv
`default_nettype none
package pbba_pkg;

  localparam int PAGE_SLOTS      = 4;
  localparam int BLOCKS_PER_PAGE = 32;
  localparam int BLOCK_BYTES     = 128;
  localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
  localparam int SIZE_W          = 16;
  localparam int SIZE_MAX        = (1 << SIZE_W) - 1;
  localparam int NBLK_W          = $clog2((SIZE_MAX + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);
  localparam int SLOT_W          = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int BLK_W           = $clog2(BLOCKS_PER_PAGE);
  localparam int CNT_W           = $clog2(BLOCKS_PER_PAGE + 1);
  localparam int SEG_W           = 16;
  localparam int SEG_STRIDE      = 'h100;
  localparam int SEGS_PER_BLOCK  = 8;
  localparam int STATUS_W        = 2;
  localparam int PIDX_W          = 2;
  localparam int FIRST_W         = 5;
  localparam int COUNT_W         = 6;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_EXISTING  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NEW_PAGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_PAGE   = 2'd3;

  // request functions
  localparam logic FUNC_ALLOC    = 1'b0;
  localparam logic FUNC_FREE_ALL = 1'b1;

  // kinds of commit issued by the controller
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] RK_FREE  = 2'd0;
  localparam logic [KIND_W-1:0] RK_LARGE = 2'd1;
  localparam logic [KIND_W-1:0] RK_PLACE = 2'd2;
  localparam logic [KIND_W-1:0] RK_OPEN  = 2'd3;

  typedef logic [BLOCKS_PER_PAGE-1:0] map_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [BLK_W-1:0]           blk_t;
  typedef logic [NBLK_W-1:0]          nblk_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              commit;
    logic [KIND_W-1:0] kind;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic hit;
    logic last_slot;
    logic out_free;
  } dp_stat_t;

  function automatic map_t low_mask(input nblk_t n);
    map_t m;
    for (int b = 0; b < BLOCKS_PER_PAGE; b++) begin
      m[b] = (NBLK_W'(b) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/pbba_if.sv
`default_nettype none
interface pbba_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [pbba_pkg::SIZE_W-1:0]    size_bytes;

  modport source (output valid, output func, output size_bytes, input ready);
  modport sink   (input valid, input func, input size_bytes, output ready);
endinterface

interface pbba_out_if;
  logic                           valid;
  logic                           ready;
  logic [pbba_pkg::STATUS_W-1:0]  status;
  logic [pbba_pkg::SEG_W-1:0]     segment;
  logic [pbba_pkg::PIDX_W-1:0]    page_index;
  logic [pbba_pkg::FIRST_W-1:0]   first_block;
  logic [pbba_pkg::COUNT_W-1:0]   block_count;

  modport source (output valid, output status, output segment, output page_index,
                  output first_block, output block_count, input ready);
  modport sink   (input valid, input status, input segment, input page_index,
                  input first_block, input block_count, output ready);
endinterface
`default_nettype wire

### sv/pbba_ctrl.sv
`default_nettype none
module pbba_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pbba_pkg::dp_stat_t  stat,
  output pbba_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OPEN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.kind     = pbba_pkg::RK_FREE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.is_free) begin
          cmd.commit = 1'b1;
          cmd.kind   = pbba_pkg::RK_FREE;
          state_nxt  = S_RESP;
        end else if (stat.too_large) begin
          cmd.commit = 1'b1;
          cmd.kind   = pbba_pkg::RK_LARGE;
          state_nxt  = S_RESP;
        end else if (stat.hit) begin
          cmd.commit = 1'b1;
          cmd.kind   = pbba_pkg::RK_PLACE;
          state_nxt  = S_RESP;
        end else if (stat.last_slot) begin
          state_nxt  = S_OPEN;
        end else begin
          cmd.step   = 1'b1;
        end
      end
      S_OPEN: begin
        cmd.commit = 1'b1;
        cmd.kind   = pbba_pkg::RK_OPEN;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        // wait until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/pbba_dpath.sv
`default_nettype none
module pbba_dpath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  pbba_pkg::dp_cmd_t                cmd,
  output pbba_pkg::dp_stat_t               stat,
  input  wire                              in_func,
  input  wire [pbba_pkg::SIZE_W-1:0]       in_size_bytes,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [pbba_pkg::STATUS_W-1:0]    out_status,
  output logic [pbba_pkg::SEG_W-1:0]       out_segment,
  output logic [pbba_pkg::PIDX_W-1:0]      out_page_index,
  output logic [pbba_pkg::FIRST_W-1:0]     out_first_block,
  output logic [pbba_pkg::COUNT_W-1:0]     out_block_count
);

  localparam int BPP = pbba_pkg::BLOCKS_PER_PAGE;
  localparam int NPS = pbba_pkg::PAGE_SLOTS;

  pbba_pkg::map_t  map_r    [NPS];
  pbba_pkg::map_t  map_nxt  [NPS];
  logic [NPS-1:0]  in_use_r;
  logic [NPS-1:0]  in_use_nxt;

  logic            func_r,  func_nxt;
  pbba_pkg::nblk_t nblk_r,  nblk_nxt;
  pbba_pkg::slot_t slot_r,  slot_nxt;

  logic [pbba_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  pbba_pkg::slot_t               res_slot_r,   res_slot_nxt;
  pbba_pkg::blk_t                res_first_r,  res_first_nxt;
  logic [pbba_pkg::CNT_W-1:0]    res_count_r,  res_count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [pbba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pbba_pkg::SEG_W-1:0]    out_segment_r, out_segment_nxt;
  logic [pbba_pkg::PIDX_W-1:0]   out_pidx_r, out_pidx_nxt;
  logic [pbba_pkg::FIRST_W-1:0]  out_first_r, out_first_nxt;
  logic [pbba_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  pbba_pkg::map_t  need;
  pbba_pkg::map_t  cur_map;
  pbba_pkg::map_t  window;
  logic [BPP-1:0]  fit;
  pbba_pkg::blk_t  fit_first;
  pbba_pkg::slot_t open_slot;
  logic            any_free;
  logic            too_large;

  assign need      = pbba_pkg::low_mask(nblk_r);
  assign cur_map   = map_r[slot_r];
  assign too_large = (nblk_r > pbba_pkg::NBLK_W'(BPP));

  // every start position is checked at once against the current page map
  always_comb begin
    fit       = '0;
    fit_first = '0;
    window    = '0;
    for (int s = 0; s < BPP; s++) begin
      window = need << s;
      fit[s] = ((int'(nblk_r) + s) <= BPP) && ((cur_map & window) == '0);
    end
    for (int s = BPP - 1; s >= 0; s--) begin
      if (fit[s]) fit_first = pbba_pkg::BLK_W'(s);
    end
  end

  always_comb begin
    open_slot = '0;
    for (int i = NPS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) open_slot = pbba_pkg::SLOT_W'(i);
    end
  end
  assign any_free = ~&in_use_r;

  assign stat.is_free   = (func_r == pbba_pkg::FUNC_FREE_ALL);
  assign stat.too_large = too_large;
  assign stat.hit       = in_use_r[slot_r] && ((nblk_r == '0) || (|fit));
  assign stat.last_slot = (slot_r == pbba_pkg::SLOT_W'(NPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    map_nxt        = map_r;
    in_use_nxt     = in_use_r;
    func_nxt       = func_r;
    nblk_nxt       = nblk_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_first_nxt  = res_first_r;
    res_count_nxt  = res_count_r;

    if (cmd.load) begin
      func_nxt = in_func;
      nblk_nxt = pbba_pkg::NBLK_W'(((pbba_pkg::SIZE_W + 1)'(in_size_bytes)
                 + (pbba_pkg::SIZE_W + 1)'(pbba_pkg::BLOCK_BYTES - 1))
                 >> pbba_pkg::BLOCK_SHIFT);
      slot_nxt = '0;
    end else if (cmd.step) begin
      slot_nxt = slot_r + pbba_pkg::SLOT_W'(1);
    end

    if (cmd.commit) begin
      res_status_nxt = pbba_pkg::STAT_EXISTING;
      res_slot_nxt   = '0;
      res_first_nxt  = '0;
      res_count_nxt  = '0;
      case (cmd.kind)
        pbba_pkg::RK_FREE: begin
          in_use_nxt = '0;
          for (int i = 0; i < NPS; i++) map_nxt[i] = '0;
        end
        pbba_pkg::RK_LARGE: begin
          res_status_nxt = pbba_pkg::STAT_TOO_LARGE;
        end
        pbba_pkg::RK_PLACE: begin
          map_nxt[slot_r] = cur_map | (need << fit_first);
          res_slot_nxt    = slot_r;
          res_first_nxt   = fit_first;
          res_count_nxt   = pbba_pkg::CNT_W'(nblk_r);
        end
        pbba_pkg::RK_OPEN: begin
          if (any_free) begin
            in_use_nxt[open_slot] = 1'b1;
            map_nxt[open_slot]    = need;
            res_status_nxt        = pbba_pkg::STAT_NEW_PAGE;
            res_slot_nxt          = open_slot;
            res_count_nxt         = pbba_pkg::CNT_W'(nblk_r);
          end else begin
            res_status_nxt = pbba_pkg::STAT_NO_PAGE;
          end
        end
        default: res_status_nxt = pbba_pkg::STAT_EXISTING;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_segment_nxt = out_segment_r;
    out_pidx_nxt    = out_pidx_r;
    out_first_nxt   = out_first_r;
    out_count_nxt   = out_count_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pidx_nxt   = pbba_pkg::PIDX_W'(res_slot_r);
      out_first_nxt  = pbba_pkg::FIRST_W'(res_first_r);
      out_count_nxt  = pbba_pkg::COUNT_W'(res_count_r);
      if (res_status_r == pbba_pkg::STAT_EXISTING || res_status_r == pbba_pkg::STAT_NEW_PAGE)
      begin
        out_segment_nxt = pbba_pkg::SEG_W'(
          (pbba_pkg::SEG_W'(res_slot_r) + pbba_pkg::SEG_W'(1))
          * pbba_pkg::SEG_W'(pbba_pkg::SEG_STRIDE)
          + pbba_pkg::SEG_W'(res_first_r) * pbba_pkg::SEG_W'(pbba_pkg::SEGS_PER_BLOCK));
      end else begin
        out_segment_nxt = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NPS; i++) map_r[i] <= '0;
    end else begin
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NPS; i++) map_r[i] <= map_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    nblk_r        <= nblk_nxt;
    slot_r        <= slot_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_first_r   <= res_first_nxt;
    res_count_r   <= res_count_nxt;
    out_status_r  <= out_status_nxt;
    out_segment_r <= out_segment_nxt;
    out_pidx_r    <= out_pidx_nxt;
    out_first_r   <= out_first_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_segment     = out_segment_r;
  assign out_page_index  = out_pidx_r;
  assign out_first_block = out_first_r;
  assign out_block_count = out_count_r;

endmodule
`default_nettype wire

### sv/paged_bitmap_block_allocator.sv
`default_nettype none
// Channel   Dir  Payload                                                   Handshake
// in_chan   in   func, size_bytes                                          valid/ready
// out_chan  out  status, segment, page_index, first_block, block_count     valid/ready
//
// An item is taken in S_IDLE, then S_SCAN tests one page map per cycle (a single page map is
// tested against all start positions at once), S_OPEN opens a fresh slot when no page has room,
// and S_RESP moves the result to the output once the output register can take it.
// Reset clears every page map and every in-use flag at once.
// The result waits in the output register; the next item is taken once it is loaded there.
module paged_bitmap_block_allocator (
  input  wire        clk,
  input  wire        rst_n,
  pbba_in_if.sink    in_chan,
  pbba_out_if.source out_chan
);

  pbba_pkg::dp_cmd_t  cmd;
  pbba_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_chan.ready = in_ready;

  pbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbba_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_chan.func),
    .in_size_bytes   (in_chan.size_bytes),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_segment     (out_chan.segment),
    .out_page_index  (out_chan.page_index),
    .out_first_block (out_chan.first_block),
    .out_block_count (out_chan.block_count)
  );

endmodule
`default_nettype wire

### verif/pbba_alloc_monitor.sv
`default_nettype none
module pbba_alloc_monitor
  import pbba_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  pbba_in_if         req_mon,
  pbba_out_if        grant_mon,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEG_W-1:0]    segment;
    logic [PIDX_W-1:0]   page_index;
    logic [FIRST_W-1:0]  first_block;
    logic [COUNT_W-1:0]  block_count;
  } grant_t;

  map_t   page_map [PAGE_SLOTS];
  logic   page_open [PAGE_SLOTS];
  grant_t grants_q [$];

  function automatic grant_t grant_at(input logic [STATUS_W-1:0] st, input int slot,
                                      input int first, input int count);
    grant_t g;
    g.status      = st;
    g.segment     = SEG_W'(SEG_STRIDE * (slot + 1) + SEGS_PER_BLOCK * first);
    g.page_index  = PIDX_W'(slot);
    g.first_block = FIRST_W'(first);
    g.block_count = COUNT_W'(count);
    return g;
  endfunction

  // First-fit placement over the open pages, then the first closed slot; free-all clears every page.
  function automatic grant_t place_request(input logic fn, input logic [SIZE_W-1:0] sz);
    grant_t g;
    int     nblk;
    map_t   run_mask;
    logic   placed;
    g      = '0;
    placed = 1'b0;
    if (fn == FUNC_FREE_ALL) begin
      for (int s = 0; s < PAGE_SLOTS; s++) begin
        page_map[s]  = '0;
        page_open[s] = 1'b0;
      end
      // reported like a grant in slot 0, block 0, so the segment is not zero
      return grant_at(STAT_EXISTING, 0, 0, 0);
    end
    nblk = (int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (nblk > BLOCKS_PER_PAGE) begin
      g.status = STAT_TOO_LARGE;
      return g;
    end
    for (int b = 0; b < BLOCKS_PER_PAGE; b++) begin
      run_mask[b] = (b < nblk);
    end
    // a zero-block request matches block 0 of the first open page
    for (int s = 0; s < PAGE_SLOTS && !placed; s++) begin
      if (page_open[s]) begin
        for (int b = 0; b + nblk <= BLOCKS_PER_PAGE && !placed; b++) begin
          if ((page_map[s] & (run_mask << b)) == '0) begin
            page_map[s] = page_map[s] | (run_mask << b);
            g      = grant_at(STAT_EXISTING, s, b, nblk);
            placed = 1'b1;
          end
        end
      end
    end
    for (int s = 0; s < PAGE_SLOTS && !placed; s++) begin
      if (!page_open[s]) begin
        page_open[s] = 1'b1;
        page_map[s]  = run_mask;
        g      = grant_at(STAT_NEW_PAGE, s, 0, nblk);
        placed = 1'b1;
      end
    end
    if (!placed) begin
      g.status = STAT_NO_PAGE;
    end
    return g;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      for (int s = 0; s < PAGE_SLOTS; s++) begin
        page_map[s]  = '0;
        page_open[s] = 1'b0;
      end
      grants_q.delete();
      outstanding <= 0;
    end else begin
      if (grant_mon.valid && grant_mon.ready) begin
        if (grants_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d segment %h",
                   $time, grant_mon.status, grant_mon.segment);
          mismatches++;
        end else begin
          want = grants_q.pop_front();
          check_field("status", want.status, grant_mon.status);
          check_field("segment", want.segment, grant_mon.segment);
          check_field("page_index", want.page_index, grant_mon.page_index);
          check_field("first_block", want.first_block, grant_mon.first_block);
          check_field("block_count", want.block_count, grant_mon.block_count);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        grants_q.push_back(place_request(req_mon.func, req_mon.size_bytes));
      end
      outstanding <= grants_q.size();
    end
  end

endmodule
`default_nettype wire

### verif/paged_bitmap_block_allocator_tb.sv
`default_nettype none
module paged_bitmap_block_allocator_tb;
  import pbba_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_WAIT     = 13;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycles;
  bit   tx_quiet;
  bit   rx_quiet;

  pbba_in_if  req_chan ();
  pbba_out_if grant_chan ();

  paged_bitmap_block_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (grant_chan)
  );

  pbba_alloc_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_chan),
    .grant_mon   (grant_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high across back-to-back items; it only drops when a gap is drawn or the bench drains
  task automatic request(input logic fn, input logic [SIZE_W-1:0] sz);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid      <= 1'b1;
    req_chan.func       <= fn;
    req_chan.size_bytes <= sz;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic alloc(input logic [SIZE_W-1:0] sz);
    request(FUNC_ALLOC, sz);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return SIZE_W'($urandom_range(0, 1024));
    if (r < 80) return SIZE_W'($urandom_range(0, 4224));
    if (r < 88) return SIZE_W'($urandom);
    // block boundaries, one byte either side
    return SIZE_W'(BLOCK_BYTES * $urandom_range(0, 33) + $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    req_chan.valid      <= 1'b0;
    req_chan.func       <= FUNC_ALLOC;
    req_chan.size_bytes <= '0;
    grant_chan.ready    <= 1'b0;
    rst_n               <= 1'b0;
    tx_quiet = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // zero size with nothing open, then into an open page
    alloc(16'd0);
    alloc(16'd0);
    alloc(16'd1);
    alloc(16'd128);
    alloc(16'd129);
    alloc(16'd4096);
    alloc(16'd4097);
    alloc(16'hFFFF);
    alloc(16'd4096);
    alloc(16'd4096);
    // all slots open, slot 0 has 4 blocks taken
    alloc(16'd4096);
    alloc(16'd3968);
    alloc(16'd0);
    alloc(16'd3584);
    alloc(16'd1);
    request(FUNC_FREE_ALL, 16'hFFFF);
    // a run that skips a nearly full page and a later one that fits its tail
    alloc(16'd3840);
    alloc(16'd384);
    alloc(16'd256);
    alloc(16'd3968);
    alloc(16'd4095);
    alloc(16'd65408);
    request(FUNC_FREE_ALL, 16'h0000);
    alloc(16'd127);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
      if (n % 500 == 499) drain();
      if ($urandom_range(0, 99) < 3) request(FUNC_FREE_ALL, SIZE_W'($urandom));
      else alloc(pick_size());
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int stall;
    int results_seen;
    results_seen = 0;
    rx_quiet     = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      // long hold-off so the block backs up and stalls its input
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        grant_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      grant_chan.ready <= 1'b1;
      @(posedge clk);
      while (!grant_chan.valid) @(posedge clk);
      results_seen++;
      if (results_seen % 150 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
`default_nettype wire

### sim.f
sv/pbba_pkg.sv
sv/pbba_if.sv
sv/pbba_ctrl.sv
sv/pbba_dpath.sv
sv/paged_bitmap_block_allocator.sv
verif/pbba_alloc_monitor.sv
verif/paged_bitmap_block_allocator_tb.sv
